### rtl/dol_pkg.sv
// shared types and codes for the depth ordered entry list
package dol_pkg;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_READ   = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_RANGE     = 2'd3;

    typedef struct packed {
        t_cmd               command;
        logic [7:0]         entry_id;
        logic signed [15:0] depth_key;
        logic [3:0]         position;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [7:0]         read_id;
        logic signed [15:0] read_key;
        logic [4:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic drop;
        logic insert;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic is_insert;
    } t_dp_stat;

endpackage

### rtl/dol_if.sv
// request and response channel interfaces
interface dol_req_if import dol_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dol_rsp_if import dol_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/dol_ctrl.sv
// command sequencer for the entry list
module dol_ctrl import dol_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_cmd     i_req_cmd,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DROP   = 4'b0010,
        S_INSERT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign w_accept    = i_req_valid && (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if ((i_req_cmd == CMD_INSERT && !i_stat.full) ||
                        i_req_cmd == CMD_REMOVE) begin
                        n_state = S_DROP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                n_state    = i_stat.is_insert ? S_INSERT : S_DONE;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/dol_datapath.sv
// slot registers, compare vectors and result register of the entry list
module dol_datapath import dol_pkg::*; #(
    parameter int LIST_DEPTH = 16,
    parameter int ID_BITS    = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [ID_BITS-1:0] r_ids  [LIST_DEPTH];
    logic [ID_BITS-1:0] n_ids  [LIST_DEPTH];
    logic signed [15:0] r_keys [LIST_DEPTH];
    logic signed [15:0] n_keys [LIST_DEPTH];
    logic [CW-1:0]      r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    logic [ID_BITS-1:0] r_id, n_id;
    logic signed [15:0] r_key, n_key;
    logic [3:0]         r_pos, n_pos;
    t_status            r_status, n_status;
    t_rsp               r_rsp, n_rsp;

    logic [LIST_DEPTH-1:0] w_valid, w_match, w_drop_sh, w_gt, w_prev_gt;
    logic [LIST_DEPTH-1:0] w_at_count, w_place;
    logic                  w_found, w_rd_hit;
    logic [ID_BITS-1:0]    w_rd_id;
    logic signed [15:0]    w_rd_key;

    always_comb begin
        logic run;
        run = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_valid[i]    = CW'(i) < r_count;
            w_at_count[i] = CW'(i) == r_count;
            w_match[i]    = w_valid[i] && (r_ids[i] == r_id);
            w_gt[i]       = w_valid[i] && (r_keys[i] > r_key);
            run           = run | w_match[i];
            w_drop_sh[i]  = run;
        end
        w_found   = run;
        w_prev_gt = {w_gt[LIST_DEPTH-2:0], 1'b0};
        w_place   = (w_gt | w_at_count) & ~w_prev_gt;
    end

    always_comb begin
        w_rd_id  = '0;
        w_rd_key = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (32'(r_pos) == 32'(i)) begin
                w_rd_id  = r_ids[i];
                w_rd_key = r_keys[i];
            end
        end
        w_rd_hit = 32'(r_pos) < 32'(r_count);
    end

    assign o_stat.full      = (r_count == CW'(LIST_DEPTH));
    assign o_stat.is_insert = (r_cmd == CMD_INSERT);
    assign o_rsp            = r_rsp;

    always_comb begin
        n_ids    = r_ids;
        n_keys   = r_keys;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_key    = r_key;
        n_pos    = r_pos;
        n_status = r_status;
        n_rsp    = r_rsp;
        if (i_cmd.load) begin
            n_cmd    = i_req.command;
            n_id     = ID_BITS'(i_req.entry_id);
            n_key    = i_req.depth_key;
            n_pos    = i_req.position;
            n_status = (i_req.command == CMD_INSERT && o_stat.full) ? ST_FULL : ST_OK;
        end
        if (i_cmd.drop) begin
            if (w_found) begin
                for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                    if (w_drop_sh[i]) begin
                        n_ids[i]  = r_ids[i+1];
                        n_keys[i] = r_keys[i+1];
                    end
                end
                n_count = r_count - CW'(1);
            end else if (r_cmd == CMD_REMOVE) begin
                n_status = ST_NOT_FOUND;
            end
        end
        if (i_cmd.insert) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (w_place[i]) begin
                    n_ids[i]  = r_id;
                    n_keys[i] = r_key;
                end
            end
            for (int i = 1; i < LIST_DEPTH; i++) begin
                if (w_prev_gt[i]) begin
                    n_ids[i]  = r_ids[i-1];
                    n_keys[i] = r_keys[i-1];
                end
            end
            n_count = r_count + CW'(1);
        end
        if (i_cmd.finish) begin
            n_rsp.status      = r_status;
            n_rsp.read_id     = '0;
            n_rsp.read_key    = '0;
            n_rsp.entry_count = 5'(r_count);
            if (r_cmd == CMD_READ) begin
                if (w_rd_hit) begin
                    n_rsp.read_id  = 8'(w_rd_id);
                    n_rsp.read_key = w_rd_key;
                end else begin
                    n_rsp.status = ST_RANGE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids    <= n_ids;
        r_keys   <= n_keys;
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

endmodule

### rtl/depth_ordered_entry_list_unit.sv
// top level of the depth ordered entry list
// Keeps up to LIST_DEPTH entry ids sorted by ascending signed depth key; an
// insert lands after equal keys and replaces any earlier copy of the same id,
// a full list refuses every insert, remove closes the gap, read returns the
// id and key at a position. One item is handled at a time by a small
// sequencer over a row of shifting slot registers: an insert passes from
// acceptance through capture, drop of an old copy, placement and result
// load, a remove through capture, drop and result load, a read, a refused
// insert or an unused code through capture and result load. The result
// load waits for as long as an earlier result still sits unaccepted at the
// output. The next item is accepted on the cycle after the result has been
// loaded, even while that result still waits at the output register.
module depth_ordered_entry_list_unit import dol_pkg::*; #(
    parameter int LIST_DEPTH = 16,
    parameter int ID_BITS    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dol_req_if.sink          i_req,
    dol_rsp_if.source        o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;
    t_rsp     w_rsp;

    dol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.data.command),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    dol_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_rsp   (w_rsp)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
    assign o_rsp.data  = w_rsp;

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while another is in work");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status == ST_FULL) |->
        (o_rsp.data.entry_count == 5'(LIST_DEPTH)))
        else $error("list full reported below capacity");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status != ST_OK) |->
        (o_rsp.data.read_id == '0 && o_rsp.data.read_key == '0))
        else $error("read data on a failed item");
`endif

endmodule

### tb/tb_depth_ordered_entry_list_unit.sv
// testbench for the depth ordered entry list: class scoreboard, randomised traffic and stalls
`timescale 1ns / 100ps

module tb_depth_ordered_entry_list_unit;
    import dol_pkg::*;

    localparam int   CLK_PERIOD  = 8;
    localparam int   LIST_SLOTS  = 16;
    localparam int   ITEM_TOTAL  = 1900;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_AT     = 600;
    localparam int   HOLD_CYCLES = 400;
    localparam t_cmd CMD_UNUSED  = 2'd3;

    class list_scoreboard;
        logic [7:0]         ids [LIST_SLOTS];
        logic signed [15:0] keys [LIST_SLOTS];
        int                 fill;
        t_rsp               expected_rsp [$];
        int                 errors;
        int                 accepted;
        int                 checked;
        int                 n_full;
        int                 n_absent;
        int                 n_range;
        int                 n_unused;
        int                 n_replace;
        int                 max_fill;

        function int locate(logic [7:0] id);
            int at;
            at = -1;
            for (int i = 0; i < fill; i++) begin
                if (at < 0 && ids[i] == id) begin
                    at = i;
                end
            end
            return at;
        endfunction

        function void close_gap(int at);
            for (int j = at; j + 1 < fill; j++) begin
                ids[j]  = ids[j + 1];
                keys[j] = keys[j + 1];
            end
            fill--;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            int   at;
            int   slot;
            e = '0;
            e.status = ST_OK;
            accepted++;
            case (r.command)
                CMD_INSERT: begin
                    if (fill >= LIST_SLOTS) begin
                        e.status = ST_FULL;
                        n_full++;
                    end else begin
                        at = locate(r.entry_id);
                        if (at >= 0) begin
                            close_gap(at);
                            n_replace++;
                        end
                        slot = fill;
                        for (int j = fill - 1; j >= 0; j--) begin
                            if (keys[j] > $signed(r.depth_key)) begin
                                slot = j;
                            end
                        end
                        for (int j = fill; j > slot; j--) begin
                            ids[j]  = ids[j - 1];
                            keys[j] = keys[j - 1];
                        end
                        ids[slot]  = r.entry_id;
                        keys[slot] = $signed(r.depth_key);
                        fill++;
                    end
                end
                CMD_REMOVE: begin
                    at = locate(r.entry_id);
                    if (at >= 0) begin
                        close_gap(at);
                    end else begin
                        e.status = ST_NOT_FOUND;
                        n_absent++;
                    end
                end
                CMD_READ: begin
                    if (int'(r.position) < fill) begin
                        e.read_id  = ids[r.position];
                        e.read_key = keys[r.position];
                    end else begin
                        e.status = ST_RANGE;
                        n_range++;
                    end
                end
                default: begin
                    n_unused++;
                end
            endcase
            if (fill > max_fill) begin
                max_fill = fill;
            end
            e.entry_count = 5'(fill);
            expected_rsp.push_back(e);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
            errors++;
        endtask

        task check_result(t_rsp got);
            t_rsp e;
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected result, status", got.status, -1);
            end else begin
                e = expected_rsp.pop_front();
                if (got.status !== e.status)
                    report_mismatch("status", got.status, e.status);
                if (got.read_id !== e.read_id)
                    report_mismatch("read_id", got.read_id, e.read_id);
                if (got.read_key !== e.read_key)
                    report_mismatch("read_key", $signed(got.read_key), $signed(e.read_key));
                if (got.entry_count !== e.entry_count)
                    report_mismatch("entry_count", got.entry_count, e.entry_count);
            end
            checked++;
        endtask

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dol_req_if req_ch ();
    dol_rsp_if rsp_ch ();

    list_scoreboard sb;
    int             cycle_count = 0;
    int             burst_left;
    int             id_base;
    bit             growing;

    depth_ordered_entry_list_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // monitors
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.data);
    end

    // receiver: switching stall patterns plus one long hold-off
    initial begin
        int  mode_left;
        int  mode;
        int  hold_left;
        bit  hold_done;
        mode_left    = 0;
        mode         = 0;
        hold_left    = 0;
        hold_done    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!hold_done && sb != null && sb.accepted >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ch.ready <= (cycle_count % 4 == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    function automatic logic signed [15:0] pick_key();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_fields(t_cmd cmd, logic [7:0] id, logic signed [15:0] key,
                               logic [3:0] pos);
        t_req r;
        r.command   = cmd;
        r.entry_id  = id;
        r.depth_key = key;
        r.position  = pos;
        send_item(r);
    endtask

    task automatic make_item(output t_req r);
        int roll;
        int stored;
        roll        = $urandom_range(0, 99);
        r.position  = 4'($urandom_range(0, 15));
        r.depth_key = pick_key();
        r.entry_id  = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                  : 8'(id_base + $urandom_range(0, 23));
        if (roll < (growing ? 60 : 20))
            r.command = CMD_INSERT;
        else if (roll < (growing ? 75 : 70))
            r.command = CMD_REMOVE;
        else if (roll < 95)
            r.command = CMD_READ;
        else
            r.command = CMD_UNUSED;
        stored = sb.fill;
        if (r.command == CMD_REMOVE && stored > 0 && $urandom_range(0, 9) < 7)
            r.entry_id = sb.ids[$urandom_range(0, stored - 1)];
    endtask

    initial begin
        t_req r;
        int   sent;
        int   phase_left;
        sb           = new();
        burst_left   = 0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, key extremes, equal keys, replacement, misses, full list
        send_fields(CMD_READ,   8'h00, 16'sh0000, 4'd0);
        send_fields(CMD_REMOVE, 8'h00, 16'sh0000, 4'd0);
        send_fields(CMD_INSERT, 8'h00, 16'sh8000, 4'd0);
        send_fields(CMD_INSERT, 8'hff, 16'sh7fff, 4'd15);
        send_fields(CMD_INSERT, 8'h55, 16'sh0000, 4'd5);
        send_fields(CMD_INSERT, 8'haa, 16'sh0000, 4'd10);
        send_fields(CMD_INSERT, 8'h55, 16'sh0000, 4'd0);
        send_fields(CMD_INSERT, 8'h33, -16'sd1,   4'd0);
        send_fields(CMD_UNUSED, 8'hff, -16'sd1,   4'd15);
        send_fields(CMD_READ,   8'h00, 16'sh0000, 4'd3);
        send_fields(CMD_READ,   8'h00, 16'sh0000, 4'd5);
        send_fields(CMD_REMOVE, 8'haa, 16'sh0000, 4'd0);
        send_fields(CMD_REMOVE, 8'h12, 16'sh0000, 4'd0);
        for (int i = 0; i < 12; i++)
            send_fields(CMD_INSERT, 8'(8'h80 + i), pick_key(), 4'd0);
        send_fields(CMD_INSERT, 8'hc3, 16'sh0100, 4'd0);
        send_fields(CMD_INSERT, 8'h00, 16'sh0100, 4'd0);
        send_fields(CMD_READ,   8'h00, 16'sh0000, 4'd15);
        sent = 28;

        // random: alternating growth and drain phases over a shifting id pool
        phase_left = 0;
        while (sent < ITEM_TOTAL) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(60, 150);
                growing    = !growing;
                id_base    = $urandom_range(0, 255);
            end
            phase_left--;
            make_item(r);
            send_item(r);
            sent++;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d items, %0d results, peak fill %0d, %0d id replacements",
                 sb.accepted, sb.checked, sb.max_fill, sb.n_replace);
        $display("refused when full %0d, ids not found %0d, reads out of range %0d, %s %0d",
                 sb.n_full, sb.n_absent, sb.n_range, "unused codes", sb.n_unused);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
